/* src/substring_first_match_search_macros.svh */
// Assertion macros used by the top level of the substring search RTL.
`ifndef SUBSTRING_FIRST_MATCH_SEARCH_MACROS_SVH
`define SUBSTRING_FIRST_MATCH_SEARCH_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SFMS_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SFMS_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sfms_pkg.sv */
// Shared types, constants and helpers for the substring search block.
`timescale 1ns / 1ps

package sfms_pkg;

  // Default sizes of the pattern store and of the position counter.
  localparam int PATTERN_MAX_DEF  = 64;
  localparam int HAYSTACK_MAX_DEF = 65536;

  // Largest start offset that can be reported.
  localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

  // Action codes of an input word.
  localparam logic ACTION_LOAD     = 1'b0;
  localparam logic ACTION_HAYSTACK = 1'b1;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IGNORE_CASE    = 2'd1;
  localparam int CFG_DATA_W = 7;

  // One input word.
  typedef struct packed {
    logic       action;
    logic [5:0] pattern_index;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [6:0] pattern_length;
    logic       ignore_case;
  } cfg_t;

  // Result of one haystack byte.
  typedef struct packed {
    logic        found;
    logic [15:0] match_offset;
  } result_t;

  // Fold ASCII upper case letters to lower case when enabled.
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic ic);
    logic [7:0] r;
    r = b;
    if (ic && (b >= 8'h41) && (b <= 8'h5A)) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

/* src/sfms_window_compare.sv */
// Parallel compare of the recent byte window against the pattern store.
`timescale 1ns / 1ps

module sfms_window_compare #(
  parameter int PATTERN_MAX = sfms_pkg::PATTERN_MAX_DEF,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic [8*PATTERN_MAX-1:0] window_flat,
  input  logic [8*PATTERN_MAX-1:0] pattern_flat,
  input  logic [LEN_W-1:0]         len,
  input  logic                     ignore_case,
  output logic                     hit
);
  import sfms_pkg::*;

  logic [8*PATTERN_MAX-1:0] window_rev;
  logic [8*PATTERN_MAX-1:0] window_aligned;
  logic [LEN_W-1:0]         shift_bytes;
  logic [PATTERN_MAX-1:0]   lane_ok;

  // Reverse the window so that the oldest byte sits in the lowest lane.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      window_rev[8*i +: 8] = window_flat[8*(PATTERN_MAX-1-i) +: 8];
    end
  end

  // Barrel shift so that lane j holds the byte that must equal pattern byte j.
  assign shift_bytes    = LEN_W'(PATTERN_MAX) - len;
  assign window_aligned = window_rev >> {shift_bytes, 3'b000};

  // Lanes beyond the pattern length always pass.
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      lane_ok[j] = (fold_byte(pattern_flat[8*j +: 8], ignore_case) ==
                    fold_byte(window_aligned[8*j +: 8], ignore_case)) ||
                   (LEN_W'(j) >= len);
    end
  end

  assign hit = &lane_ok;

endmodule

/* src/sfms_core.sv */
// Pattern store, byte window and first-match tracking state.
`timescale 1ns / 1ps

module sfms_core #(
  parameter int PATTERN_MAX  = sfms_pkg::PATTERN_MAX_DEF,
  parameter int HAYSTACK_MAX = sfms_pkg::HAYSTACK_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  sfms_pkg::item_t   item,
  input  sfms_pkg::cfg_t    cfg,
  output sfms_pkg::result_t res
);
  import sfms_pkg::*;

  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int POS_W = $clog2(HAYSTACK_MAX + 1);
  localparam int EXT_W = POS_W + 1;

  logic [PATTERN_MAX-1:0][7:0] pattern_store;
  logic [PATTERN_MAX-1:0][7:0] window;
  logic [PATTERN_MAX-1:0][7:0] window_next;
  logic [POS_W-1:0]            bytes_seen;
  logic                        match_seen;
  logic [15:0]                 first_offset;

  logic [IDX_W-1:0] waddr;
  logic             load_ok;
  logic             hay_step;
  logic [LEN_W-1:0] eff_len;
  logic [EXT_W-1:0] pos_plus1;
  logic [EXT_W-1:0] start;
  logic             window_hit;
  logic             match_now;

  // Pattern store writes; indexes past the store are dropped.
  assign waddr   = IDX_W'(item.pattern_index);
  assign load_ok = (32'(item.pattern_index) < PATTERN_MAX);

  always_ff @(posedge clk) begin
    if (step && (item.action == ACTION_LOAD) && load_ok) begin
      pattern_store[waddr] <= item.data_byte;
    end
  end

  // Shift the new byte into the window; entry 0 is the newest.
  always_comb begin
    window_next[0] = item.data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      window_next[k] = window[k-1];
    end
  end

  assign hay_step = step && (item.action == ACTION_HAYSTACK);

  always_ff @(posedge clk) begin
    if (hay_step) begin
      window <= window_next;
    end
  end

  // Pattern length, limited to the store depth.
  always_comb begin
    if (32'(cfg.pattern_length) > PATTERN_MAX) begin
      eff_len = LEN_W'(PATTERN_MAX);
    end else begin
      eff_len = LEN_W'(cfg.pattern_length);
    end
  end

  sfms_window_compare #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W)
  ) u_compare (
    .window_flat  (window_next),
    .pattern_flat (pattern_store),
    .len          (eff_len),
    .ignore_case  (cfg.ignore_case),
    .hit          (window_hit)
  );

  // A match counts only if it is the first, lies in range and the window is full enough.
  assign pos_plus1 = EXT_W'(bytes_seen) + EXT_W'(1);
  assign start     = pos_plus1 - EXT_W'(eff_len);
  assign match_now = !match_seen && (eff_len != '0) &&
                     (32'(bytes_seen) < HAYSTACK_MAX) &&
                     (pos_plus1 >= EXT_W'(eff_len)) &&
                     (32'(start) <= 32'(OFFSET_MAX)) && window_hit;

  // Result seen when this byte closes the haystack.
  assign res.found        = match_seen || match_now;
  assign res.match_offset = match_now ? 16'(start) : first_offset;

  // Stream state: position counter and first match, cleared after the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen   <= '0;
      match_seen   <= 1'b0;
      first_offset <= '0;
    end else if (hay_step) begin
      if (item.last_byte) begin
        bytes_seen   <= '0;
        match_seen   <= 1'b0;
        first_offset <= '0;
      end else begin
        if (32'(bytes_seen) < HAYSTACK_MAX) begin
          bytes_seen <= bytes_seen + POS_W'(1);
        end
        if (match_now) begin
          match_seen   <= 1'b1;
          first_offset <= 16'(start);
        end
      end
    end
  end

endmodule

/* src/substring_first_match_search.sv */
// Top level of the streaming first-match substring search block.
`timescale 1ns / 1ps
`include "substring_first_match_search_macros.svh"

// Streaming first-match substring search. Load words (action 0) write pattern
// bytes; haystack words (action 1) stream one byte each, and the word with
// last_byte set returns one result word with found and the start offset of
// the first match. The block takes one word per clock while no result is held
// back: a word sits in an input register while the full window compare and the
// match state update run, and a result word appears on the output register at the
// edge at which its last byte leaves the input register. The sustained rate of
// one word per cycle is set by that compare-and-update loop on the position
// counter and match state. A result waiting to be taken holds back only a
// haystack last byte that reaches the input register, and the words queued
// behind it; other words keep flowing. Configuration writes are taken in any
// cycle.
module substring_first_match_search #(
  parameter int PATTERN_MAX  = sfms_pkg::PATTERN_MAX_DEF,
  parameter int HAYSTACK_MAX = sfms_pkg::HAYSTACK_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic [5:0]                       pattern_index,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             found,
  output logic [15:0]                      match_offset,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sfms_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfms_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sfms_pkg::*;

  logic    in_full;
  item_t   in_item;
  cfg_t    cfg;
  result_t res;
  logic    emits;
  logic    step;

  // Configuration registers, always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length <= 7'd1;
      cfg.ignore_case    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data;
        REG_IGNORE_CASE:    cfg.ignore_case    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The held word moves on unless it produces a result that has nowhere to go.
  assign emits    = (in_item.action == ACTION_HAYSTACK) && in_item.last_byte;
  assign step     = in_full && (!emits || !out_valid || out_ready);
  assign in_ready = !in_full || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item.action        <= action;
      in_item.pattern_index <= pattern_index;
      in_item.data_byte     <= data_byte;
      in_item.last_byte     <= last_byte;
    end
  end

  sfms_core #(
    .PATTERN_MAX  (PATTERN_MAX),
    .HAYSTACK_MAX (HAYSTACK_MAX)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emits) begin
      found        <= res.found;
      match_offset <= res.match_offset;
    end
  end

  // A missing match always reports offset zero.
  `SFMS_ASSERT_IMP(a_offset_zero, clk, rst, out_valid && !found, match_offset == 16'd0, "offset set without match")
  // A closing byte that moves on shows a result in the next cycle.
  `SFMS_ASSERT_NXT(a_result_follows, clk, rst, step && emits, out_valid, "result word lost")
  // A closing byte is held while the previous result waits.
  `SFMS_ASSERT_IMP(a_no_overwrite, clk, rst, in_full && emits && out_valid && !out_ready, !in_ready && !step, "result overwritten")

endmodule
